// File: src/msrp_pkg.sv
// Shared types and constants for the microphone sample / RMS / pre-roll block.
// Used by the front, queue, back, RMS unit and top level; depends on nothing.
package msrp_pkg;

    // Item kinds as carried in the input tuser field
    typedef enum logic [1:0] {
        KIND_SAMPLE = 2'd0,
        KIND_READ   = 2'd1,
        KIND_CLEAR  = 2'd2
    } t_kind;

    localparam logic [4:0]         SHIFT_RESET = 5'd11;
    localparam logic signed [31:0] SAMPLE_MAX  = 32'sd32767;
    localparam logic signed [31:0] SAMPLE_MIN  = -32'sd32768;

    // Frame sum, quotient, divisor and root widths
    localparam int SUM_W  = 40;
    localparam int CNT_W  = 11;
    localparam int ROOT_W = SUM_W / 2;
    localparam int REM_W  = ROOT_W + 1;
    localparam int STEP_W = 6;

    // Classified item handed from the front to the back
    typedef struct packed {
        t_kind              kind;
        logic signed [15:0] sample;
        logic               last;
        logic [12:0]        read_max;
        logic [11:0]        read_pos;
    } t_cmd;

    // Request and response of the divide / square-root unit
    typedef struct packed {
        logic             start;
        logic [SUM_W-1:0] sum;
        logic [CNT_W-1:0] count;
    } t_rms_req;

    typedef struct packed {
        logic              done;
        logic [ROOT_W-1:0] root;
    } t_rms_rsp;

    typedef enum logic [1:0] {
        R_IDLE,
        R_DIV,
        R_SQRT,
        R_DONE
    } t_rms_state;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_ACCUM,
        ST_RMS,
        ST_OUT
    } t_back_state;

endpackage

// File: src/msrp_front.sv
// Front end: accepts input requests, conditions raw samples and pushes commands.
// Depends on msrp_pkg; feeds msrp_queue.
module msrp_front
    import msrp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // tdata: raw_sample[31:0], read_max[44:32], read_position[56:45]
    input  logic [63:0] i_s_tdata,
    // tuser: kind[1:0]
    input  logic [1:0]  i_s_tuser,
    input  logic        i_s_tlast,
    input  logic [4:0]  i_shift_bits,
    input  logic        i_full,
    output logic        o_push,
    output t_cmd        o_cmd
);

    logic signed [31:0] raw;
    logic signed [31:0] shifted;
    logic signed [15:0] clamped;
    logic               r_seen;

    // Track that the front has left reset before taking requests
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= 1'b0;
        end else begin
            r_seen <= 1'b1;
        end
    end

    // Shift and clamp the raw word to signed 16 bits
    always_comb begin
        raw     = $signed(i_s_tdata[31:0]);
        shifted = raw >>> i_shift_bits;
        if (shifted > SAMPLE_MAX) begin
            clamped = SAMPLE_MAX[15:0];
        end else if (shifted < SAMPLE_MIN) begin
            clamped = SAMPLE_MIN[15:0];
        end else begin
            clamped = shifted[15:0];
        end
    end

    // Classify and push while the queue has room
    always_comb begin
        o_s_tready      = r_seen && !i_full;
        o_push          = i_s_tvalid && o_s_tready;
        o_cmd.kind      = t_kind'(i_s_tuser);
        o_cmd.sample    = clamped;
        o_cmd.last      = i_s_tlast;
        o_cmd.read_max  = i_s_tdata[44:32];
        o_cmd.read_pos  = i_s_tdata[56:45];
    end

endmodule

// File: src/msrp_queue.sv
// Two-entry command queue between the front and the back.
// Depends on msrp_pkg for the command type.
module msrp_queue
    import msrp_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output logic o_avail,
    output t_cmd o_cmd
);

    t_cmd       r_slot [2];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_avail = (r_cnt != 2'd0);
    assign o_cmd   = r_slot[r_rptr];

    // Store pushed commands
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wptr] <= i_cmd;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wptr <= ~r_wptr;
            end
            if (i_pop) begin
                r_rptr <= ~r_rptr;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// File: src/msrp_rms.sv
// Frame RMS unit: restoring divide of the square sum by the count, one bit per
// cycle, then a digit-by-digit square root, one bit pair per cycle. Uses msrp_pkg.
module msrp_rms
    import msrp_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_rms_req i_req,
    output t_rms_rsp o_rsp
);

    t_rms_state        r_state;
    t_rms_state        n_state;
    logic [SUM_W-1:0]  r_quo;
    logic [CNT_W-1:0]  r_div;
    logic [CNT_W-1:0]  r_rem;
    logic [REM_W-1:0]  r_srem;
    logic [ROOT_W-1:0] r_root;
    logic [STEP_W-1:0] r_step;

    logic [CNT_W:0]    rem_sh;
    logic              qbit;
    logic [CNT_W:0]    rem_next;
    logic [REM_W+1:0]  s_sh;
    logic [REM_W+1:0]  trial;
    logic              sbit;
    logic [REM_W+1:0]  s_next;
    logic              div_last;
    logic              sqrt_last;

    // Divide and root step logic
    always_comb begin
        rem_sh    = {r_rem, r_quo[SUM_W-1]};
        qbit      = (rem_sh >= {1'b0, r_div});
        rem_next  = qbit ? (rem_sh - {1'b0, r_div}) : rem_sh;
        s_sh      = {r_srem, r_quo[SUM_W-1:SUM_W-2]};
        trial     = (REM_W+2)'({r_root, 2'b01});
        sbit      = (s_sh >= trial);
        s_next    = sbit ? (s_sh - trial) : s_sh;
        div_last  = (r_step == STEP_W'(SUM_W - 1));
        sqrt_last = (r_step == STEP_W'(ROOT_W - 1));
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            R_IDLE:  if (i_req.start) n_state = R_DIV;
            R_DIV:   if (div_last) n_state = R_SQRT;
            R_SQRT:  if (sqrt_last) n_state = R_DONE;
            R_DONE:  n_state = R_IDLE;
            default: n_state = R_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        o_rsp.done = (r_state == R_DONE);
        o_rsp.root = r_root;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= R_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Iteration datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            R_IDLE: begin
                r_quo  <= i_req.sum;
                r_div  <= i_req.count;
                r_rem  <= '0;
                r_step <= '0;
            end
            R_DIV: begin
                r_rem  <= rem_next[CNT_W-1:0];
                r_quo  <= {r_quo[SUM_W-2:0], qbit};
                r_srem <= '0;
                r_root <= '0;
                r_step <= div_last ? '0 : r_step + STEP_W'(1);
            end
            R_SQRT: begin
                r_srem <= s_next[REM_W-1:0];
                r_root <= {r_root[ROOT_W-2:0], sbit};
                r_quo  <= {r_quo[SUM_W-3:0], 2'b00};
                r_step <= r_step + STEP_W'(1);
            end
            default: begin
                r_step <= '0;
            end
        endcase
    end

endmodule

// File: src/msrp_back.sv
// Back end: executes queued commands on the pre-roll ring and frame sum, and
// holds each result until taken. Depends on msrp_pkg and talks to msrp_rms.
module msrp_back
    import msrp_pkg::*;
#(
    parameter int PREROLL_DEPTH = 4096,
    parameter int FRAME_MAX     = 512
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_avail,
    input  t_cmd        i_cmd,
    output logic        o_pop,
    output t_rms_req    o_rms_req,
    input  t_rms_rsp    i_rms_rsp,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // tdata: sample_out[15:0], rms_level[31:16], preroll_fill[44:32],
    //        read_available[57:45], preroll_sample[73:58], zero fill above
    output logic [79:0] o_m_tdata,
    // tuser: rms_valid[0], preroll_valid[1]
    output logic [1:0]  o_m_tuser
);

    localparam int AW  = $clog2(PREROLL_DEPTH);
    localparam int FW  = $clog2(PREROLL_DEPTH + 1);
    localparam int WW  = ((FW > 13) ? FW : 13) + 1;
    localparam int FCW = $clog2(FRAME_MAX + 1);

    t_back_state        r_state;
    t_back_state        n_state;
    t_cmd               r_cmd;
    logic signed [15:0] r_ring [PREROLL_DEPTH];
    logic signed [15:0] r_mem_q;
    logic [AW-1:0]      r_head;
    logic [FW-1:0]      r_fill;
    logic [SUM_W-1:0]   r_sum;
    logic [FCW-1:0]     r_count;
    logic [15:0]        r_rms_hold;
    logic [31:0]        r_sq;
    logic [12:0]        r_avail;
    logic               r_pvalid;
    logic               r_frame_end;

    logic               mem_we;
    logic               mem_re;
    logic               frame_end;
    logic [SUM_W:0]     sum_add;
    logic [SUM_W-1:0]   sum_sat;
    logic [FCW-1:0]     count_new;
    logic signed [31:0] sq_full;
    logic [WW-1:0]      req_w;
    logic [WW-1:0]      fill_w;
    logic [WW-1:0]      avail_w;
    logic [WW-1:0]      pos_w;
    logic [WW-1:0]      t_w;
    logic [WW-1:0]      addr_w;
    logic               pvalid;

    // Frame accumulation
    always_comb begin
        sq_full   = $signed(r_cmd.sample) * $signed(r_cmd.sample);
        sum_add   = {1'b0, r_sum} + (SUM_W+1)'(r_sq);
        sum_sat   = sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
        count_new = r_count + FCW'(1);
        frame_end = r_cmd.last || (count_new >= FCW'(FRAME_MAX));
    end

    // Ring read window and address, oldest of the available samples first
    always_comb begin
        req_w   = WW'(r_cmd.read_max);
        fill_w  = WW'(r_fill);
        avail_w = (fill_w < req_w) ? fill_w : req_w;
        pos_w   = WW'(r_cmd.read_pos);
        pvalid  = (pos_w < avail_w);
        t_w     = WW'(r_head) + pos_w;
        addr_w  = (t_w >= avail_w) ? (t_w - avail_w)
                                   : (t_w + WW'(PREROLL_DEPTH) - avail_w);
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_avail) n_state = ST_EXEC;
            end
            ST_EXEC: begin
                n_state = (r_cmd.kind == KIND_SAMPLE) ? ST_ACCUM : ST_OUT;
            end
            ST_ACCUM: begin
                n_state = frame_end ? ST_RMS : ST_OUT;
            end
            ST_RMS: begin
                if (i_rms_rsp.done) n_state = ST_OUT;
            end
            ST_OUT: begin
                if (i_m_tready) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Control outputs
    always_comb begin
        o_pop           = (r_state == ST_IDLE) && i_avail;
        mem_we          = (r_state == ST_EXEC) && (r_cmd.kind == KIND_SAMPLE);
        mem_re          = (r_state == ST_EXEC) && (r_cmd.kind == KIND_READ);
        o_rms_req.start = (r_state == ST_ACCUM) && frame_end;
        o_rms_req.sum   = sum_sat;
        o_rms_req.count = CNT_W'(count_new);
        o_m_tvalid      = (r_state == ST_OUT);
    end

    // Assemble the held result
    always_comb begin
        o_m_tdata        = '0;
        o_m_tdata[15:0]  = (r_cmd.kind == KIND_SAMPLE) ? r_cmd.sample : 16'sd0;
        o_m_tdata[31:16] = r_rms_hold;
        o_m_tdata[44:32] = fill_w[12:0];
        o_m_tdata[57:45] = r_avail;
        o_m_tdata[73:58] = r_pvalid ? r_mem_q : 16'sd0;
        o_m_tuser        = {r_pvalid, r_frame_end};
    end

    // Ring memory with registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_ring[r_head] <= r_cmd.sample;
        end
        if (mem_re) begin
            r_mem_q <= r_ring[addr_w[AW-1:0]];
        end
    end

    // Control and architectural state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_head     <= '0;
            r_fill     <= '0;
            r_sum      <= '0;
            r_count    <= '0;
            r_rms_hold <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_EXEC) begin
                case (r_cmd.kind)
                    KIND_SAMPLE: begin
                        r_head <= (r_head == AW'(PREROLL_DEPTH - 1)) ? '0
                                                                     : r_head + AW'(1);
                        if (r_fill != FW'(PREROLL_DEPTH)) begin
                            r_fill <= r_fill + FW'(1);
                        end
                    end
                    KIND_CLEAR: begin
                        r_head <= '0;
                        r_fill <= '0;
                    end
                    default: begin
                        r_head <= r_head;
                    end
                endcase
            end
            if (r_state == ST_ACCUM) begin
                if (frame_end) begin
                    r_sum   <= '0;
                    r_count <= '0;
                end else begin
                    r_sum   <= sum_sat;
                    r_count <= count_new;
                end
            end
            if ((r_state == ST_RMS) && i_rms_rsp.done) begin
                r_rms_hold <= i_rms_rsp.root[15:0];
            end
        end
    end

    // Per-item payload
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cmd <= i_cmd;
        end
        if (r_state == ST_EXEC) begin
            r_sq        <= 32'(unsigned'(sq_full));
            r_frame_end <= 1'b0;
            if (r_cmd.kind == KIND_READ) begin
                r_avail  <= avail_w[12:0];
                r_pvalid <= pvalid;
            end else begin
                r_avail  <= '0;
                r_pvalid <= 1'b0;
            end
        end
        if (r_state == ST_ACCUM) begin
            r_frame_end <= frame_end;
        end
    end

endmodule

// File: src/mic_sample_rms_preroll.sv
// Microphone sample conditioning with frame RMS and a pre-roll ring.
// Read and clear requests pass from the queue through an execute step to the held
// result; samples add an accumulate step, and a frame-ending sample also waits for
// the divide and square root. The back end handles one item at a time and takes no
// new item from the queue until the last result is taken; a two-entry queue keeps
// accepting while a result waits. Reset is synchronous, active low: it empties the
// ring and the frame sum, zeroes the held RMS and sets shift_bits to 11.
module mic_sample_rms_preroll
    import msrp_pkg::*;
#(
    parameter int PREROLL_DEPTH = 4096,
    parameter int FRAME_MAX     = 512
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [4:0]  i_cfg_data,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // tdata: raw_sample[31:0], read_max[44:32], read_position[56:45], zero fill
    input  logic [63:0] i_s_tdata,
    // tuser: kind[1:0]
    input  logic [1:0]  i_s_tuser,
    // tlast: frame_last
    input  logic        i_s_tlast,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // tdata: sample_out[15:0], rms_level[31:16], preroll_fill[44:32],
    //        read_available[57:45], preroll_sample[73:58], zero fill
    output logic [79:0] o_m_tdata,
    // tuser: rms_valid[0], preroll_valid[1]
    output logic [1:0]  o_m_tuser
);

    logic [4:0] r_shift_bits;
    logic       push;
    logic       full;
    logic       pop;
    logic       avail;
    t_cmd       front_cmd;
    t_cmd       queue_cmd;
    t_rms_req   rms_req;
    t_rms_rsp   rms_rsp;

    assign o_cfg_ready = 1'b1;

    // Hold the gain shift register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift_bits <= SHIFT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_shift_bits <= i_cfg_data;
        end
    end

    msrp_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (i_s_tvalid),
        .o_s_tready   (o_s_tready),
        .i_s_tdata    (i_s_tdata),
        .i_s_tuser    (i_s_tuser),
        .i_s_tlast    (i_s_tlast),
        .i_shift_bits (r_shift_bits),
        .i_full       (full),
        .o_push       (push),
        .o_cmd        (front_cmd)
    );

    msrp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .o_full  (full),
        .i_pop   (pop),
        .o_avail (avail),
        .o_cmd   (queue_cmd)
    );

    msrp_rms u_rms (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (rms_req),
        .o_rsp   (rms_rsp)
    );

    msrp_back #(
        .PREROLL_DEPTH (PREROLL_DEPTH),
        .FRAME_MAX     (FRAME_MAX)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_avail    (avail),
        .i_cmd      (queue_cmd),
        .o_pop      (pop),
        .o_rms_req  (rms_req),
        .i_rms_rsp  (rms_rsp),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

endmodule
